// File: hw/rtl/assert_macros.svh
// Assertion macros used by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SFIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies a condition in the next.
`define SFIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/sfir_pkg.sv
// Types and fixed constants of the symmetric FIR filter.
package sfir_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEFF_W    = 16;
  localparam int NREGS      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int PAIR_W     = SAMPLE_W + 1;
  localparam int PROD_W     = PAIR_W + COEFF_W;
  localparam int ACC_W      = 40;
  localparam int FRAC_BITS  = 15;
  localparam int ROUND_BIAS = 16384;
  localparam int SAT_MAX    = 32767;
  localparam int SAT_MIN    = -32768;
  localparam int GROUP_SIZE = 4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEFF_W-1:0]  coeff_t;
  typedef logic signed [PAIR_W-1:0]   pair_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       last_in;
  } in_req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_out;
  } out_req_t;

endpackage

// File: hw/rtl/sfir_taps.sv
// Delay line, fill tracking and pre-adder stage of the symmetric FIR filter.
module sfir_taps #(
  parameter int TAPS = 15
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  sfir_pkg::in_req_t                      in_req,
  output logic                                   pre_valid,
  input  logic                                   pre_stall,
  output sfir_pkg::pair_t                        pre_pair [(TAPS-1)/2 + 1],
  output logic                                   pre_last,
  output logic [$clog2(TAPS)-1:0]                fill_cnt
);

  localparam int DEPTH  = TAPS - 1;
  localparam int HALF   = (TAPS - 1) / 2;
  localparam int LANES  = HALF + 1;
  localparam int FILL_W = $clog2(TAPS);

  sfir_pkg::sample_t delay_r [DEPTH];
  sfir_pkg::sample_t win     [TAPS];
  sfir_pkg::pair_t   pair_nxt [LANES];
  sfir_pkg::pair_t   pair_r   [LANES];
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic              pre_valid_r;
  logic              pre_last_r;
  logic              accept;
  logic              full;

  assign in_stall = pre_valid_r && pre_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (fill_r == FILL_W'(DEPTH));

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      win[i] = delay_r[i];
    end
    win[DEPTH] = in_req.sample_in;
  end

  // Fold mirrored samples before the multipliers.
  always_comb begin
    pair_nxt[0] = sfir_pkg::PAIR_W'(win[HALF]);
    for (int d = 1; d < LANES; d++) begin
      pair_nxt[d] = sfir_pkg::PAIR_W'(win[HALF-d]) + sfir_pkg::PAIR_W'(win[HALF+d]);
    end
  end

  always_comb begin
    if (in_req.last_in) begin
      fill_nxt = '0;
    end else if (full) begin
      fill_nxt = fill_r;
    end else begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      pre_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        fill_r <= fill_nxt;
      end
      if (!in_stall) begin
        pre_valid_r <= in_valid && full;
      end
    end
  end

  // Samples held before a full window are never read, so the line needs no clear.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < DEPTH; i++) begin
        delay_r[i] <= win[i+1];
      end
      pair_r     <= pair_nxt;
      pre_last_r <= in_req.last_in;
    end
  end

  assign pre_valid = pre_valid_r;
  assign pre_pair  = pair_r;
  assign pre_last  = pre_last_r;
  assign fill_cnt  = fill_r;

endmodule

// File: hw/rtl/sfir_mac.sv
// Coefficient multipliers and partial sums of the symmetric FIR filter.
module sfir_mac #(
  parameter int TAPS = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_stall,
  input  sfir_pkg::pair_t   up_pair [(TAPS-1)/2 + 1],
  input  logic              up_last,
  input  sfir_pkg::coeff_t  coeff [sfir_pkg::NREGS],
  output logic              grp_valid,
  input  logic              grp_stall_in,
  output sfir_pkg::acc_t    grp_sum [((TAPS-1)/2 + sfir_pkg::GROUP_SIZE) / sfir_pkg::GROUP_SIZE],
  output logic              grp_last
);

  localparam int HALF   = (TAPS - 1) / 2;
  localparam int LANES  = HALF + 1;
  localparam int GSZ    = sfir_pkg::GROUP_SIZE;
  localparam int GROUPS = (LANES + GSZ - 1) / GSZ;

  sfir_pkg::coeff_t coef_lane [LANES];
  sfir_pkg::prod_t  prod_nxt  [LANES];
  sfir_pkg::prod_t  prod_r    [LANES];
  sfir_pkg::acc_t   grp_nxt   [GROUPS];
  sfir_pkg::acc_t   grp_r     [GROUPS];
  logic             mul_v_r;
  logic             mul_last_r;
  logic             grp_v_r;
  logic             grp_last_r;
  logic             mul_stall;
  logic             grp_stall;

  // Distances past the register file get no weight.
  for (genvar l = 0; l < LANES; l++) begin : g_coef
    if (l < sfir_pkg::NREGS) begin : g_used
      assign coef_lane[l] = coeff[l];
    end else begin : g_zero
      assign coef_lane[l] = '0;
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      prod_nxt[l] = sfir_pkg::PROD_W'(up_pair[l]) * sfir_pkg::PROD_W'(coef_lane[l]);
    end
  end

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GSZ; k++) begin
        if (g * GSZ + k < LANES) begin
          grp_nxt[g] = grp_nxt[g] + sfir_pkg::ACC_W'(prod_r[g * GSZ + k]);
        end
      end
    end
  end

  assign grp_stall = grp_v_r && grp_stall_in;
  assign mul_stall = mul_v_r && grp_stall;
  assign up_stall  = mul_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
      grp_v_r <= 1'b0;
    end else begin
      if (!mul_stall) begin
        mul_v_r <= up_valid;
      end
      if (!grp_stall) begin
        grp_v_r <= mul_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!mul_stall && up_valid) begin
      prod_r     <= prod_nxt;
      mul_last_r <= up_last;
    end
    if (!grp_stall && mul_v_r) begin
      grp_r      <= grp_nxt;
      grp_last_r <= mul_last_r;
    end
  end

  assign grp_valid = grp_v_r;
  assign grp_sum   = grp_r;
  assign grp_last  = grp_last_r;

endmodule

// File: hw/rtl/sfir_round.sv
// Final sum, rounding, saturation and result register of the symmetric FIR filter.
module sfir_round #(
  parameter int TAPS = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_stall,
  input  sfir_pkg::acc_t     up_sum [((TAPS-1)/2 + sfir_pkg::GROUP_SIZE) / sfir_pkg::GROUP_SIZE],
  input  logic               up_last,
  output logic               out_valid,
  input  logic               out_stall,
  output sfir_pkg::out_req_t out_req
);

  localparam int HALF   = (TAPS - 1) / 2;
  localparam int LANES  = HALF + 1;
  localparam int GSZ    = sfir_pkg::GROUP_SIZE;
  localparam int GROUPS = (LANES + GSZ - 1) / GSZ;
  localparam int Q_W    = sfir_pkg::ACC_W - sfir_pkg::FRAC_BITS;

  sfir_pkg::acc_t     acc;
  sfir_pkg::acc_t     biased;
  logic signed [Q_W-1:0] q;
  sfir_pkg::sample_t  sat;
  logic               out_valid_r;
  sfir_pkg::out_req_t out_req_r;

  always_comb begin
    acc = '0;
    for (int g = 0; g < GROUPS; g++) begin
      acc = acc + up_sum[g];
    end
    // Round half up, then floor shift.
    biased = acc + sfir_pkg::ACC_W'(sfir_pkg::ROUND_BIAS);
    q      = Q_W'(biased >>> sfir_pkg::FRAC_BITS);
    if (q > Q_W'(sfir_pkg::SAT_MAX)) begin
      sat = sfir_pkg::SAMPLE_W'(sfir_pkg::SAT_MAX);
    end else if (q < Q_W'(sfir_pkg::SAT_MIN)) begin
      sat = sfir_pkg::SAMPLE_W'(sfir_pkg::SAT_MIN);
    end else begin
      sat = q[sfir_pkg::SAMPLE_W-1:0];
    end
  end

  assign up_stall = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!up_stall) begin
      out_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      out_req_r.sample_out <= sat;
      out_req_r.last_out   <= up_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

endmodule

// File: hw/rtl/symmetric_fir15_s16.sv
// out_valid rises once an accepted sample has passed the pre-add, multiply, partial
// sum and round/saturate registers. Throughput: one sample per clock
// while no stage stalls; a stall passes back combinationally to in_stall, so empty stages
// keep taking requests. The first TAPS-1 samples of a block give no result.
// Reset (synchronous, rst_n low) zeroes the coefficients, the fill count and all stage
// valid bits; the delay line contents are not cleared.
`include "assert_macros.svh"

module symmetric_fir15_s16 #(
  parameter int TAPS = 15
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  sfir_pkg::in_req_t               in_req,
  output logic                            out_valid,
  input  logic                            out_stall,
  output sfir_pkg::out_req_t              out_req,
  input  logic                            cfg_wr_en,
  input  logic [sfir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfir_pkg::COEFF_W-1:0]    cfg_wdata
);

  localparam int DEPTH  = TAPS - 1;
  localparam int HALF   = (TAPS - 1) / 2;
  localparam int LANES  = HALF + 1;
  localparam int GSZ    = sfir_pkg::GROUP_SIZE;
  localparam int GROUPS = (LANES + GSZ - 1) / GSZ;
  localparam int FILL_W = $clog2(TAPS);

  sfir_pkg::coeff_t  coeff_r [sfir_pkg::NREGS];
  sfir_pkg::pair_t   pre_pair [LANES];
  sfir_pkg::acc_t    grp_sum  [GROUPS];
  logic              pre_valid;
  logic              pre_last;
  logic              mac_stall;
  logic              grp_valid;
  logic              grp_last;
  logic              rnd_stall;
  logic [FILL_W-1:0] fill_cnt;
  logic              in_accept;
  logic              blk_end;
  logic              fill_grow;
  logic              fill_hold;

  assign in_accept = in_valid && !in_stall;
  assign blk_end   = in_accept && in_req.last_in;
  assign fill_grow = in_accept && !in_req.last_in && (fill_cnt != FILL_W'(DEPTH));
  assign fill_hold = in_accept && !in_req.last_in && (fill_cnt == FILL_W'(DEPTH));

  // Drop writes to distances the filter does not have.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sfir_pkg::NREGS; i++) begin
        coeff_r[i] <= '0;
      end
    end else if (cfg_wr_en && (int'(cfg_index) <= HALF)) begin
      coeff_r[cfg_index] <= $signed(cfg_wdata);
    end
  end

  sfir_taps #(
    .TAPS(TAPS)
  ) u_taps (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .pre_valid (pre_valid),
    .pre_stall (mac_stall),
    .pre_pair  (pre_pair),
    .pre_last  (pre_last),
    .fill_cnt  (fill_cnt)
  );

  sfir_mac #(
    .TAPS(TAPS)
  ) u_mac (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (pre_valid),
    .up_stall     (mac_stall),
    .up_pair      (pre_pair),
    .up_last      (pre_last),
    .coeff        (coeff_r),
    .grp_valid    (grp_valid),
    .grp_stall_in (rnd_stall),
    .grp_sum      (grp_sum),
    .grp_last     (grp_last)
  );

  sfir_round #(
    .TAPS(TAPS)
  ) u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (grp_valid),
    .up_stall  (rnd_stall),
    .up_sum    (grp_sum),
    .up_last   (grp_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

  `SFIR_ASSERT_NEXT(a_last_clears_fill, blk_end, fill_cnt == '0, "fill not cleared at end of block")
  `SFIR_ASSERT_NEXT(a_fill_inc, fill_grow, fill_cnt == $past(fill_cnt) + 1'b1, "fill not advanced")
  `SFIR_ASSERT_NEXT(a_fill_hold, fill_hold, fill_cnt == FILL_W'(DEPTH), "full line lost its fill state")
  `SFIR_ASSERT(a_stall_needs_pre, !pre_valid |-> !in_stall, "input stalled with pre-add stage empty")

endmodule

// File: test/symmetric_fir15_s16_test.sv
// Self-checking testbench for the symmetric 15-tap FIR filter with random handshake gaps.
module symmetric_fir15_s16_test;

  localparam int TAPS = 15;
  localparam int DEPTH = TAPS - 1;
  localparam int HALF = (TAPS - 1) / 2;
  localparam int RANDOM_ITEMS = 1850;
  localparam int MAX_WAIT = 19;
  localparam int DRAIN_CYCLES = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_LIMIT = 200;
  localparam int DIR_ROWS = 23;

  localparam sfir_pkg::sample_t S_MAX = 16'sh7fff;
  localparam sfir_pkg::sample_t S_MIN = 16'sh8000;

  typedef enum logic [sfir_pkg::CFG_IDX_W-1:0] {
    REG_CENTER, REG_DIST1, REG_DIST2, REG_DIST3,
    REG_DIST4, REG_DIST5, REG_DIST6, REG_DIST7
  } coeff_reg_e;

  typedef enum int {
    CMODE_RANDOM, CMODE_ALL_MAX, CMODE_ALL_MIN, CMODE_SMALL,
    CMODE_ALTERNATE, CMODE_CENTER_ONLY, CMODE_PARTIAL
  } coeff_mode_e;

  typedef enum int {SMODE_FULL, SMODE_SMALL, SMODE_EXTREME} sample_mode_e;

  typedef enum {ROW_SAMPLE, ROW_COEFFS} row_kind_e;

  // ROW_COEFFS loads value into every coefficient; pinned rows carry a hand-read result
  typedef struct {
    row_kind_e         kind;
    sfir_pkg::sample_t value;
    bit                last;
    bit                pinned;
    sfir_pkg::sample_t pinned_out;
  } stim_row_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  sfir_pkg::in_req_t  in_req = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  sfir_pkg::out_req_t out_req;
  logic               cfg_wr_en = 1'b0;
  logic [sfir_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sfir_pkg::COEFF_W-1:0]   cfg_wdata = '0;

  sfir_pkg::sample_t  hist [DEPTH] = '{default: '0};
  int                 hist_fill = 0;
  sfir_pkg::coeff_t   coeff_set [sfir_pkg::NREGS] = '{default: '0};
  sfir_pkg::out_req_t pending_out [$];
  int                 mismatches = 0;
  int                 quiet_cycles = 0;
  int                 out_hold = 0;
  bit                 in_idle_on = 1'b1;
  bit                 out_idle_on = 1'b1;
  stim_row_t          dir_rows [DIR_ROWS];

  symmetric_fir15_s16 #(.TAPS(TAPS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int draw_wait(bit enabled);
    return enabled ? int'($urandom_range(0, MAX_WAIT)) : 0;
  endfunction

  function automatic sfir_pkg::sample_t draw_sample(sample_mode_e mode);
    case (mode)
      SMODE_SMALL: return sfir_pkg::sample_t'($urandom_range(0, 511)) - 16'sd256;
      SMODE_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return S_MAX;
          1: return S_MIN;
          2: return -16'sd1;
          default: return sfir_pkg::sample_t'($urandom);
        endcase
      end
      default: return sfir_pkg::sample_t'($urandom);
    endcase
  endfunction

  // Filter one sample against the held window, then advance the delay line or clear it on last.
  function automatic bit filter_step(sfir_pkg::sample_t x, bit last,
                                     output sfir_pkg::out_req_t res);
    sfir_pkg::sample_t win [TAPS];
    longint            acc;
    longint            q;
    bit                fired;
    for (int i = 0; i < DEPTH; i++) win[i] = hist[i];
    win[DEPTH] = x;
    fired = (hist_fill >= DEPTH);
    res = '0;
    if (fired) begin
      acc = longint'(win[HALF]) * longint'(coeff_set[REG_CENTER]);
      for (int d = 1; d <= HALF; d++)
        acc += (longint'(win[HALF-d]) + longint'(win[HALF+d])) * longint'(coeff_set[d]);
      q = (acc + sfir_pkg::ROUND_BIAS) >>> sfir_pkg::FRAC_BITS;
      if (q > sfir_pkg::SAT_MAX) q = sfir_pkg::SAT_MAX;
      else if (q < sfir_pkg::SAT_MIN) q = sfir_pkg::SAT_MIN;
      res.sample_out = sfir_pkg::sample_t'(q);
      res.last_out = last;
    end
    if (last) begin
      for (int i = 0; i < DEPTH; i++) hist[i] = '0;
      hist_fill = 0;
    end else begin
      for (int i = 0; i < DEPTH; i++) hist[i] = win[i+1];
      if (hist_fill < DEPTH) hist_fill++;
    end
    return fired;
  endfunction

  task automatic report(string what, int got, int want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic take_result(sfir_pkg::out_req_t got);
    sfir_pkg::out_req_t want;
    if (pending_out.size() == 0) begin
      report("unexpected result, sample_out", got.sample_out, 0);
    end else begin
      want = pending_out.pop_front();
      if (got.sample_out !== want.sample_out)
        report("sample_out", got.sample_out, want.sample_out);
      if (got.last_out !== want.last_out)
        report("last_out", got.last_out, want.last_out);
    end
  endtask

  // Hold valid across back-to-back requests; lower it only when a gap is drawn.
  task automatic push_sample(sfir_pkg::sample_t x, bit last, bit pinned,
                             sfir_pkg::sample_t pinned_out);
    int                 gap;
    sfir_pkg::out_req_t res;
    bit                 fired;
    gap = draw_wait(in_idle_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= '{sample_in: x, last_in: last};
    do @(posedge clk); while (in_stall !== 1'b0);
    fired = filter_step(x, last, res);
    if (fired) begin
      if (pinned) res.sample_out = pinned_out;
      pending_out.push_back(res);
    end
  endtask

  // Drop valid, wait for every pending result, then let fill-only samples drain.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_coeff(coeff_reg_e r, sfir_pkg::coeff_t v);
    cfg_wr_en <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    coeff_set[r] = v;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      take_result(out_req);
      out_hold = draw_wait(out_idle_on);
    end
    out_stall <= (out_hold > 0);
    if (out_hold > 0) out_hold--;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int               sent;
    int               phase;
    int               phase_len;
    int               phase_sent;
    int               blk_len;
    coeff_mode_e      cmode;
    sample_mode_e     smode;
    sfir_pkg::coeff_t val;

    // short block, then a full window of minimum samples, saturation both ways, two last-flagged samples
    dir_rows = '{
      '{ROW_SAMPLE, S_MAX, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, S_MIN, 1'b1, 1'b0, '0},
      '{ROW_SAMPLE, S_MIN, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, S_MIN, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, S_MIN, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, S_MIN, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, S_MIN, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, S_MIN, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, S_MIN, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, S_MIN, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, S_MIN, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, S_MIN, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, S_MIN, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, S_MIN, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, S_MIN, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, S_MIN, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, S_MIN, 1'b0, 1'b1, 16'sh0000},
      '{ROW_COEFFS, S_MIN, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, S_MIN, 1'b0, 1'b1, S_MAX},
      '{ROW_COEFFS, S_MAX, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, S_MAX, 1'b0, 1'b1, S_MIN},
      '{ROW_SAMPLE, 16'sh0000, 1'b1, 1'b0, '0},
      '{ROW_SAMPLE, 16'sh0001, 1'b1, 1'b0, '0}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_COEFFS) begin
        quiesce();
        for (int i = 0; i < sfir_pkg::NREGS; i++)
          load_coeff(coeff_reg_e'(i), dir_rows[r].value);
        cfg_wr_en <= 1'b0;
      end else begin
        push_sample(dir_rows[r].value, dir_rows[r].last, dir_rows[r].pinned,
                    dir_rows[r].pinned_out);
      end
    end

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      quiesce();
      if (phase == 0) cmode = CMODE_ALL_MAX;
      else if (phase == 1) cmode = CMODE_ALL_MIN;
      else cmode = coeff_mode_e'($urandom_range(CMODE_RANDOM, CMODE_PARTIAL));
      for (int i = 0; i < sfir_pkg::NREGS; i++) begin
        case (cmode)
          CMODE_ALL_MAX: val = S_MAX;
          CMODE_ALL_MIN: val = S_MIN;
          CMODE_SMALL: val = sfir_pkg::coeff_t'($urandom_range(0, 2047)) - 16'sd1024;
          CMODE_ALTERNATE: val = (i % 2) ? S_MIN : S_MAX;
          CMODE_CENTER_ONLY: val = (i == REG_CENTER) ? sfir_pkg::coeff_t'($urandom) : '0;
          default: val = sfir_pkg::coeff_t'($urandom);
        endcase
        // partial mode leaves most registers at their previous setting
        if (cmode != CMODE_PARTIAL || $urandom_range(0, 2) == 0)
          load_coeff(coeff_reg_e'(i), val);
      end
      cfg_wr_en <= 1'b0;

      in_idle_on = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      smode = sample_mode_e'($urandom_range(SMODE_FULL, SMODE_EXTREME));
      phase_len = $urandom_range(60, 250);
      phase_sent = 0;
      while (phase_sent < phase_len && sent < RANDOM_ITEMS) begin
        if ($urandom_range(0, 6) == 0) blk_len = $urandom_range(1, DEPTH);
        else blk_len = $urandom_range(TAPS, 4 * TAPS);
        for (int k = 0; k < blk_len; k++)
          push_sample(draw_sample(smode), k == blk_len - 1, 1'b0, '0);
        sent += blk_len;
        phase_sent += blk_len;
      end
      phase++;
    end

    quiesce();
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
